// File: rtl/core/rrp_pkg.sv
// Shared types and constants for the record ring producer.
package rrp_pkg;

	localparam int META_SLOTS    = 4;
	localparam int LENGTH_SHIFT  = 0;
	localparam int LENGTH_BITS   = 7;
	localparam int OVERRUN_BIT   = 7;

	localparam int SLOT_W        = 13;
	localparam int SIZE_W        = SLOT_W + 1;
	localparam int LOG2_W        = 4;
	localparam int DATA_W        = 32;
	localparam int PADDR_W       = 4;
	localparam int REG_IDX_W     = 2;

	localparam logic [LOG2_W-1:0] SIZE_LOG2_MIN = LOG2_W'(9);
	localparam logic [LOG2_W-1:0] SIZE_LOG2_MAX = LOG2_W'(13);
	localparam logic [SLOT_W-1:0] META_SLOT     = SLOT_W'(META_SLOTS);

	localparam logic [REG_IDX_W-1:0] REG_ENABLED   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SIZE_LOG2 = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CLOSED    = 2'd2;

	typedef enum logic [1:0] {
		ST_POSTED   = 2'd0,
		ST_OVERRUN  = 2'd1,
		ST_REFUSED  = 2'd2,
		ST_ZERO_LEN = 2'd3
	} status_t;

	typedef struct packed {
		logic              enabled;
		logic [LOG2_W-1:0] size_log2;
		logic              closed;
	} cfg_t;

	typedef struct packed {
		status_t           status;
		logic              pad_written;
		logic [SLOT_W-1:0] pad_slot;
		logic [SLOT_W-1:0] pad_length;
		logic              meta_reset;
		logic [SLOT_W-1:0] record_slot;
		logic [DATA_W-1:0] info_out;
		logic [DATA_W-1:0] new_head;
		logic              wake;
	} result_t;

endpackage

// File: rtl/core/rrp_cfg.sv
// APB register file holding the ring configuration.
module rrp_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rrp_pkg::PADDR_W-1:0] paddr,
	input  logic [rrp_pkg::DATA_W-1:0]  pwdata,
	output logic [rrp_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output rrp_pkg::cfg_t               cfg
);

	rrp_pkg::cfg_t                   cfg_q;
	logic [rrp_pkg::REG_IDX_W-1:0]   idx;
	logic                            wr_en;

	assign idx    = paddr[rrp_pkg::PADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled   <= 1'b0;
			cfg_q.size_log2 <= rrp_pkg::SIZE_LOG2_MIN;
			cfg_q.closed    <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				rrp_pkg::REG_ENABLED:   cfg_q.enabled   <= pwdata[0];
				rrp_pkg::REG_SIZE_LOG2: cfg_q.size_log2 <= pwdata[rrp_pkg::LOG2_W-1:0];
				rrp_pkg::REG_CLOSED:    cfg_q.closed    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			rrp_pkg::REG_ENABLED:   prdata = rrp_pkg::DATA_W'(cfg_q.enabled);
			rrp_pkg::REG_SIZE_LOG2: prdata = rrp_pkg::DATA_W'(cfg_q.size_log2);
			rrp_pkg::REG_CLOSED:    prdata = rrp_pkg::DATA_W'(cfg_q.closed);
			default:                prdata = '0;
		endcase
	end

endmodule

// File: rtl/core/rrp_post.sv
// Combinational post decision: tail check, end pad, metadata skip, space check.
module rrp_post (
	input  rrp_pkg::cfg_t               cfg,
	input  logic [rrp_pkg::DATA_W-1:0]  note_info,
	input  logic [rrp_pkg::DATA_W-1:0]  consumer_tail,
	input  logic                        sender_permitted,
	input  logic [rrp_pkg::DATA_W-1:0]  head,
	input  logic                        pend,
	output rrp_pkg::result_t            res,
	output logic [rrp_pkg::DATA_W-1:0]  head_nxt,
	output logic                        pend_nxt
);

	localparam int SW = rrp_pkg::SLOT_W;
	localparam int ZW = rrp_pkg::SIZE_W;
	localparam int DW = rrp_pkg::DATA_W;

	logic [rrp_pkg::LOG2_W-1:0]      lg;
	logic [ZW-1:0]                   size;
	logic [SW-1:0]                   mask;
	logic [rrp_pkg::LENGTH_BITS-1:0] len;
	logic [ZW-1:0]                   len_x;
	logic [DW-1:0]                   used;
	logic [SW-1:0]                   t;
	logic [SW-1:0]                   h;
	logic [ZW-1:0]                   seg;
	logic [DW-1:0]                   head_base;
	logic                            go;
	logic                            fail;
	logic                            pad;
	logic                            meta;
	logic [SW-1:0]                   hh;
	logic [SW-1:0]                   pad_slot;
	logic [SW-1:0]                   pad_len;
	logic [DW-1:0]                   head_w;
	logic                            posted;
	rrp_pkg::status_t                st;

	always_comb begin
		priority if (cfg.size_log2 < rrp_pkg::SIZE_LOG2_MIN) lg = rrp_pkg::SIZE_LOG2_MIN;
		else if (cfg.size_log2 > rrp_pkg::SIZE_LOG2_MAX)     lg = rrp_pkg::SIZE_LOG2_MAX;
		else                                                  lg = cfg.size_log2;
	end

	assign size      = ZW'(1) << lg;
	assign mask      = SW'(size - ZW'(1));
	assign len       = note_info[rrp_pkg::LENGTH_SHIFT +: rrp_pkg::LENGTH_BITS];
	assign len_x     = ZW'(len);
	assign used      = head - consumer_tail;
	assign t         = consumer_tail[SW-1:0] & mask;
	assign h         = head[SW-1:0] & mask;
	assign seg       = size - ZW'(h);
	assign head_base = head & ~DW'(mask);
	assign go        = cfg.enabled & (len != '0) & ~cfg.closed & sender_permitted;

	always_comb begin
		fail     = 1'b0;
		pad      = 1'b0;
		meta     = 1'b0;
		hh       = h;
		pad_slot = '0;
		pad_len  = '0;
		head_w   = head;
		if ((used >= DW'(size)) || ((t != '0) && (t < rrp_pkg::META_SLOT)))
			fail = 1'b1;
		if (!fail && (h >= t) && (len_x > seg)) begin
			if ((t >= rrp_pkg::META_SLOT) && (len_x > ZW'(t - rrp_pkg::META_SLOT))) begin
				fail = 1'b1;
			end else begin
				pad      = 1'b1;
				pad_slot = h;
				pad_len  = seg[SW-1:0];
				head_w   = head_base + DW'(size);
				hh       = '0;
				if (t == '0)
					fail = 1'b1;
			end
		end
		if (!fail && (hh == '0)) begin
			meta   = 1'b1;
			head_w = head_w + DW'(rrp_pkg::META_SLOTS);
			hh     = rrp_pkg::META_SLOT;
			if (rrp_pkg::META_SLOT >= t)
				fail = 1'b1;
		end
		if (!fail && (hh < t) && (len_x > ZW'(t - hh)))
			fail = 1'b1;
	end

	assign posted = go & ~fail;

	always_comb begin
		priority if (!cfg.enabled)                        st = rrp_pkg::ST_REFUSED;
		else if (len == '0)                               st = rrp_pkg::ST_ZERO_LEN;
		else if (cfg.closed || !sender_permitted)         st = rrp_pkg::ST_REFUSED;
		else if (fail)                                    st = rrp_pkg::ST_OVERRUN;
		else                                              st = rrp_pkg::ST_POSTED;
	end

	assign res.status      = st;
	assign res.pad_written = go & pad;
	assign res.pad_slot    = go ? pad_slot : '0;
	assign res.pad_length  = go ? pad_len : '0;
	assign res.meta_reset  = go & meta;
	assign res.record_slot = posted ? hh : '0;
	assign res.info_out    = posted ? (note_info | (DW'(pend) << rrp_pkg::OVERRUN_BIT)) : '0;
	assign res.new_head    = posted ? (head_w + DW'(len)) : head;
	assign res.wake        = posted & (used == '0);

	assign head_nxt = res.new_head;
	assign pend_nxt = posted ? 1'b0 : ((go & fail) | pend);

endmodule

// File: rtl/core/record_ring_producer.sv
// Record ring producer top level: input register, post logic, result register.
// A request in the input register moves through the post logic into the result register
// when that one is empty or being drained. Throughput: one request per cycle while
// out_ready holds; head and overrun state loop back as each result is registered.
// Reset: head just past the metadata block, overrun flag clear, ring disabled
// at the minimum size, both stages empty.
module record_ring_producer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rrp_pkg::PADDR_W-1:0] paddr,
	input  logic [rrp_pkg::DATA_W-1:0]  pwdata,
	output logic [rrp_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [31:0]                 note_info,
	input  logic [31:0]                 consumer_tail,
	input  logic                        sender_permitted,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic                        pad_written,
	output logic [12:0]                 pad_slot,
	output logic [12:0]                 pad_length,
	output logic                        meta_reset,
	output logic [12:0]                 record_slot,
	output logic [31:0]                 info_out,
	output logic [31:0]                 new_head,
	output logic                        wake
);

	rrp_pkg::cfg_t                  cfg;
	rrp_pkg::result_t               res;
	rrp_pkg::result_t               result_q;
	logic [rrp_pkg::DATA_W-1:0]     info_s1;
	logic [rrp_pkg::DATA_W-1:0]     tail_s1;
	logic                           perm_s1;
	logic                           valid_s1;
	logic [rrp_pkg::DATA_W-1:0]     head_q;
	logic                           pend_q;
	logic                           out_valid_q;
	logic [rrp_pkg::DATA_W-1:0]     head_nxt;
	logic                           pend_nxt;
	logic                           adv;
	logic                           take;

	rrp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rrp_post u_post (
		.cfg              (cfg),
		.note_info        (info_s1),
		.consumer_tail    (tail_s1),
		.sender_permitted (perm_s1),
		.head             (head_q),
		.pend             (pend_q),
		.res              (res),
		.head_nxt         (head_nxt),
		.pend_nxt         (pend_nxt)
	);

	assign adv      = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | adv;
	assign take     = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			head_q      <= rrp_pkg::DATA_W'(rrp_pkg::META_SLOTS);
			pend_q      <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv) begin
				out_valid_q <= 1'b1;
				head_q      <= head_nxt;
				pend_q      <= pend_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			info_s1 <= note_info;
			tail_s1 <= consumer_tail;
			perm_s1 <= sender_permitted;
		end
		if (adv)
			result_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign status      = result_q.status;
	assign pad_written = result_q.pad_written;
	assign pad_slot    = result_q.pad_slot;
	assign pad_length  = result_q.pad_length;
	assign meta_reset  = result_q.meta_reset;
	assign record_slot = result_q.record_slot;
	assign info_out    = result_q.info_out;
	assign new_head    = result_q.new_head;
	assign wake        = result_q.wake;

`ifndef SYNTHESIS
	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv || (res.status != rrp_pkg::ST_POSTED)) |=> $stable(head_q))
		else $error("head moved without a posted request");

	a_pend_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (res.status == rrp_pkg::ST_POSTED)) |=> !pend_q)
		else $error("overrun flag not cleared by a post");

	a_pend_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (res.status == rrp_pkg::ST_OVERRUN)) |=> pend_q)
		else $error("overrun flag not armed");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output register");
`endif

endmodule

// File: bench/ring_post_checker.sv
// Checker for the record ring producer: tracks config, predicts each post, compares results.
module ring_post_checker
	import rrp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [31:0]        note_info,
	input  logic [31:0]        consumer_tail,
	input  logic               sender_permitted,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         status,
	input  logic               pad_written,
	input  logic [12:0]        pad_slot,
	input  logic [12:0]        pad_length,
	input  logic               meta_reset,
	input  logic [12:0]        record_slot,
	input  logic [31:0]        info_out,
	input  logic [31:0]        new_head,
	input  logic               wake,
	output int                 fail_count,
	output int                 open_posts,
	output logic [31:0]        head_now,
	output int                 n_checked,
	output int                 n_posted,
	output int                 n_overrun,
	output int                 n_pads,
	output int                 n_meta
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t    ring_cfg;
	logic    overrun_armed;
	result_t post_results_q[$];
	int      mismatches = 0;
	int      checked_cnt = 0;
	int      posted_cnt = 0;
	int      overrun_cnt = 0;
	int      pad_cnt = 0;
	int      meta_cnt = 0;

	assign fail_count = mismatches;
	assign n_checked  = checked_cnt;
	assign n_posted   = posted_cnt;
	assign n_overrun  = overrun_cnt;
	assign n_pads     = pad_cnt;
	assign n_meta     = meta_cnt;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40) begin
			$display("ERROR %0t ns: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
				checked_cnt, name, got, want));
		end
	endtask

	function automatic result_t predict_post(
		input  logic [31:0] info,
		input  logic [31:0] tail,
		input  logic        permitted,
		input  logic [31:0] head_in,
		input  logic        armed_in,
		output logic [31:0] head_out,
		output logic        armed_out
	);
		result_t     r;
		logic [3:0]  lg;
		logic [31:0] slots, mask, len, used, t, h, hd;
		logic        fits;
		r = '0;
		r.status = ST_OVERRUN;
		r.new_head = head_in;
		head_out = head_in;
		armed_out = armed_in;
		lg = ring_cfg.size_log2;
		if (lg < SIZE_LOG2_MIN) lg = SIZE_LOG2_MIN;
		if (lg > SIZE_LOG2_MAX) lg = SIZE_LOG2_MAX;
		slots = 32'd1 << lg;
		mask = slots - 32'd1;
		len = (info >> LENGTH_SHIFT) & ((32'd1 << LENGTH_BITS) - 32'd1);
		if (!ring_cfg.enabled) begin
			r.status = ST_REFUSED;
		end else if (len == 0) begin
			r.status = ST_ZERO_LEN;
		end else if (ring_cfg.closed || !permitted) begin
			r.status = ST_REFUSED;
		end else begin
			used = head_in - tail;
			t = tail & mask;
			h = head_in & mask;
			hd = head_in;
			fits = (used < slots) && !(t > 0 && t < 32'(META_SLOTS));
			// record would cross the ring end: pad to the end, unless the tail blocks it
			if (fits && h >= t && len > slots - h) begin
				if (t >= 32'(META_SLOTS) && len > t - 32'(META_SLOTS)) begin
					fits = 1'b0;
				end else begin
					r.pad_written = 1'b1;
					r.pad_slot = SLOT_W'(h);
					r.pad_length = SLOT_W'(slots - h);
					hd = hd + slots - h;
					h = '0;
					if (t == 0) fits = 1'b0;
				end
			end
			if (fits && h == 0) begin
				r.meta_reset = 1'b1;
				hd = hd + 32'(META_SLOTS);
				h = 32'(META_SLOTS);
				if (h >= t) fits = 1'b0;
			end
			if (fits && h < t && len > t - h) fits = 1'b0;
			if (fits) begin
				r.status = ST_POSTED;
				r.info_out = info | (32'(armed_in) << OVERRUN_BIT);
				r.record_slot = SLOT_W'(h);
				hd = hd + len;
				r.new_head = hd;
				r.wake = (used == 0);
				head_out = hd;
				armed_out = 1'b0;
			end else begin
				armed_out = 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t     want;
		logic [31:0] next_head;
		logic        next_armed;
		if (!arst_n) begin
			ring_cfg.enabled <= 1'b0;
			ring_cfg.size_log2 <= SIZE_LOG2_MIN;
			ring_cfg.closed <= 1'b0;
			head_now <= 32'(META_SLOTS);
			overrun_armed <= 1'b0;
			post_results_q.delete();
			open_posts <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_ENABLED:   ring_cfg.enabled <= pwdata[0];
					REG_SIZE_LOG2: ring_cfg.size_log2 <= pwdata[LOG2_W-1:0];
					REG_CLOSED:    ring_cfg.closed <= pwdata[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (post_results_q.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = post_results_q.pop_front();
					checked_cnt++;
					if (want.status == ST_POSTED) posted_cnt++;
					if (want.status == ST_OVERRUN) overrun_cnt++;
					if (want.pad_written) pad_cnt++;
					if (want.meta_reset) meta_cnt++;
					check_field("status", 32'(status), 32'(want.status));
					check_field("pad_written", 32'(pad_written), 32'(want.pad_written));
					check_field("pad_slot", 32'(pad_slot), 32'(want.pad_slot));
					check_field("pad_length", 32'(pad_length), 32'(want.pad_length));
					check_field("meta_reset", 32'(meta_reset), 32'(want.meta_reset));
					check_field("record_slot", 32'(record_slot), 32'(want.record_slot));
					check_field("info_out", info_out, want.info_out);
					check_field("new_head", new_head, want.new_head);
					check_field("wake", 32'(wake), 32'(want.wake));
				end
			end
			if (in_valid && in_ready) begin
				want = predict_post(note_info, consumer_tail, sender_permitted,
					head_now, overrun_armed, next_head, next_armed);
				post_results_q.push_back(want);
				head_now <= next_head;
				overrun_armed <= next_armed;
			end
			open_posts <= post_results_q.size();
		end
	end

endmodule

// File: bench/record_ring_producer_tb.sv
// Testbench top for the record ring producer: reset, config, request stimulus and verdict.
module record_ring_producer_tb;
	import rrp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] LEN_MAX = (32'd1 << LENGTH_BITS) - 32'd1;
	localparam int          QUIET_LIMIT = 1000;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [31:0]        note_info = '0;
	logic [31:0]        consumer_tail = '0;
	logic               sender_permitted = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic               pad_written;
	logic [12:0]        pad_slot;
	logic [12:0]        pad_length;
	logic               meta_reset;
	logic [12:0]        record_slot;
	logic [31:0]        info_out;
	logic [31:0]        new_head;
	logic               wake;

	int                 fail_count;
	int                 open_posts;
	logic [31:0]        head_now;
	int                 n_checked, n_posted, n_overrun, n_pads, n_meta;

	int unsigned        ring_slots = 512;
	logic               idle_on = 1'b1;
	int                 stall_left = 0;
	int                 quiet_cycles = 0;

	record_ring_producer u_dut (.*);
	ring_post_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 3);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Timeout: no progress for %0d cycles", QUIET_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_ring(input logic en, input logic [3:0] lg, input logic closed);
		write_reg(REG_ENABLED, 32'(en));
		write_reg(REG_SIZE_LOG2, 32'(lg));
		write_reg(REG_CLOSED, 32'(closed));
		ring_slots = 1 << ((lg < SIZE_LOG2_MIN) ? SIZE_LOG2_MIN :
			(lg > SIZE_LOG2_MAX) ? SIZE_LOG2_MAX : lg);
	endtask

	task automatic settle();
		@(posedge clk);
		while (open_posts != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] tail_at_slot(input int unsigned slot);
		logic [31:0] h, base;
		h = head_now & (ring_slots - 1);
		base = head_now - h;
		return (slot <= h) ? base + slot : base - ring_slots + slot;
	endfunction

	function automatic void make_post(output logic [31:0] info, output logic [31:0] tail,
		output logic perm);
		logic [31:0] len;
		int unsigned roll;
		int unsigned slot;
		roll = $urandom_range(0, 9);
		if (roll < 3) len = $urandom_range(1, 8);
		else if (roll < 7) len = $urandom_range(1, LEN_MAX);
		else len = $urandom_range(LEN_MAX - 27, LEN_MAX);
		info = ($urandom & ~(LEN_MAX << LENGTH_SHIFT)) | (len << LENGTH_SHIFT);
		perm = 1'b1;
		tail = head_now;
		roll = $urandom_range(0, 99);
		if (roll < 65) begin
			case ($urandom_range(0, 9))
				0, 1:       tail = head_now;
				2, 3, 4, 5: tail = head_now - $urandom_range(0, ring_slots / 2);
				6, 7:       tail = head_now - $urandom_range(ring_slots / 2, ring_slots - 1);
				8:          tail = head_now - ring_slots + $urandom_range(1, 8);
				default: begin
					case ($urandom_range(0, 3))
						0:       slot = 0;
						1:       slot = META_SLOTS;
						2:       slot = $urandom_range(1, META_SLOTS - 1);
						default: slot = $urandom_range(0, ring_slots - 1);
					endcase
					tail = tail_at_slot(slot);
				end
			endcase
		end else if (roll < 75) begin
			info = info & ~(LEN_MAX << LENGTH_SHIFT);
		end else if (roll < 85) begin
			perm = 1'b0;
		end else if (roll < 92) begin
			tail = head_now - ring_slots - $urandom_range(0, 1000);
		end else begin
			info = $urandom;
			tail = $urandom;
			perm = 1'($urandom_range(0, 1));
		end
	endfunction

	// one request, then wait for the ring to drain so head_now is current
	task automatic post_now(input logic [31:0] info, input logic [31:0] tail, input logic perm);
		in_valid <= 1'b1;
		note_info <= info;
		consumer_tail <= tail;
		sender_permitted <= perm;
		do @(posedge clk); while (!in_ready);
		in_valid <= 1'b0;
		settle();
	endtask

	task automatic post_random();
		logic [31:0] info, tail;
		logic        perm;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		make_post(info, tail, perm);
		in_valid <= 1'b1;
		note_info <= info;
		consumer_tail <= tail;
		sender_permitted <= perm;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic run_phase(input int count, input bit calm);
		for (int i = 0; i < count; i++) begin
			idle_on <= !calm && ((i / 100) % 3 != 2);
			post_random();
		end
		in_valid <= 1'b0;
		settle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ring disabled: refused even ahead of the zero-length check
		post_now(32'hFFFF_FFFF, head_now, 1'b1);
		post_now(32'h0000_0000, head_now, 1'b0);
		set_ring(1'b1, 4'd0, 1'b1);
		post_now(32'hFFFF_FF00, head_now, 1'b1);
		post_now(32'h0000_0005, head_now, 1'b1);
		set_ring(1'b1, 4'd0, 1'b0);
		post_now(32'h0000_0005, head_now, 1'b0);
		post_now(32'hFFFF_FFFF, head_now, 1'b1);
		post_now(32'h0000_0010, head_now - ring_slots, 1'b1);
		post_now(32'h0000_0010, tail_at_slot(1), 1'b1);
		post_now(32'h0000_0003, head_now, 1'b1);
		while (((head_now & (ring_slots - 1)) + LEN_MAX) < ring_slots) begin
			post_now(32'h8000_007F, head_now, 1'b1);
		end
		// wrap cases: pad then tail at slot 0, tail right past metadata, clean wrap
		post_now(32'h0000_007F, tail_at_slot(0), 1'b1);
		post_now(32'h0000_007F, tail_at_slot(META_SLOTS), 1'b1);
		post_now(32'h5A5A_A57F, tail_at_slot(200), 1'b1);
		while (((head_now & (ring_slots - 1)) + LEN_MAX) < ring_slots) begin
			post_now(32'h8000_007F, head_now, 1'b1);
		end
		post_now(32'(ring_slots) - (head_now & (ring_slots - 1)), head_now, 1'b1);
		// head at slot 0 with empty ring: overrun with metadata reset flagged, then a post
		post_now(32'h0000_000A, head_now, 1'b1);
		post_now(32'h0000_0014, tail_at_slot(300), 1'b1);

		set_ring(1'b1, 4'd9, 1'b0);
		run_phase(300, 1'b0);
		set_ring(1'b1, 4'd13, 1'b0);
		run_phase(250, 1'b0);
		set_ring(1'b1, 4'd15, 1'b0);
		run_phase(150, 1'b0);
		set_ring(1'b1, 4'd8, 1'b0);
		run_phase(150, 1'b0);
		set_ring(1'b1, 4'd11, 1'b1);
		run_phase(60, 1'b0);
		set_ring(1'b0, 4'd10, 1'b0);
		run_phase(60, 1'b0);
		set_ring(1'b1, 4'd12, 1'b0);
		run_phase(250, 1'b0);
		set_ring(1'b1, 4'd10, 1'b0);
		run_phase(250, 1'b1);

		repeat (8) @(posedge clk);
		$display("Checked %0d requests over ring sizes 512 to 8192 slots: %0d posted, %0d overrun,",
			n_checked, n_posted, n_overrun);
		$display("%0d refused or zero length; %0d end pads and %0d metadata rewrites seen.",
			n_checked - n_posted - n_overrun, n_pads, n_meta);
		if (fail_count == 0 && open_posts == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
